FILE: hdl/crt_pkg.sv
`default_nettype none

package crt_pkg;

	localparam int NODE_W     = 8;
	localparam int VALUE_W    = 32;
	localparam int DEMAND_W   = 24;
	localparam int CAP_W      = 24;
	localparam int LOAD_W     = 25;
	localparam int COUNT_W    = 9;
	localparam int TOTAL_W    = 48;
	localparam int SUM_W      = TOTAL_W + 1;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam int OPS_W      = 2;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_VEHICLE_CAPACITY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEPOT_NODE       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT       = 2'd2;

	localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 9'd256;

	typedef enum logic [1:0] {
		REQ_LOAD_DIST   = 2'd0,
		REQ_LOAD_DEMAND = 2'd1,
		REQ_VISIT       = 2'd2,
		REQ_END         = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		OP_LEG   = 2'd0,
		OP_WRITE = 2'd1,
		OP_EMIT  = 2'd2
	} op_kind_t;

	// one unit of work for the back end
	typedef struct packed {
		op_kind_t            kind;
		logic [NODE_W-1:0]   from_node;
		logic [NODE_W-1:0]   to_node;
		logic [VALUE_W-1:0]  value;
	} op_t;

	function automatic op_t make_leg(logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
		op_t o;
		o.kind      = OP_LEG;
		o.from_node = a;
		o.to_node   = b;
		o.value     = '0;
		return o;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/crt_if.sv
`default_nettype none

interface crt_req_if import crt_pkg::*;;
	logic                valid;
	logic                ready;
	logic [1:0]          req_type;
	logic [NODE_W-1:0]   node;
	logic [NODE_W-1:0]   to_node;
	logic [VALUE_W-1:0]  value;
	logic                route_end;

	modport source(output valid, req_type, node, to_node, value, route_end, input ready);
	modport sink(input valid, req_type, node, to_node, value, route_end, output ready);
endinterface

interface crt_res_if import crt_pkg::*;;
	logic                valid;
	logic                ready;
	logic [TOTAL_W-1:0]  total_distance;
	logic                invalid;

	modport source(output valid, total_distance, invalid, input ready);
	modport sink(input valid, total_distance, invalid, output ready);
endinterface

interface crt_cfg_if import crt_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hdl/crt_front.sv
`default_nettype none

module crt_front import crt_pkg::*; #(
	parameter int MAX_NODES = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	crt_req_if.sink                req,
	input  wire logic [CAP_W-1:0]  vehicle_capacity,
	input  wire logic [NODE_W-1:0] depot_node,
	output logic                   push,
	output op_t                    push_op,
	input  wire logic              full
);

	localparam int NW = $clog2(MAX_NODES);

	logic [DEMAND_W-1:0] dem_mem [MAX_NODES];

	logic                accept;
	logic                in_tbl;

	// stage 1: registered item and demand read
	logic                valid_s1;
	req_type_t           type_s1;
	logic [NODE_W-1:0]   node_s1;
	logic [NODE_W-1:0]   to_s1;
	logic [VALUE_W-1:0]  value_s1;
	logic                rend_s1;
	logic [DEMAND_W-1:0] dem_rd_s1;
	logic                dem_ok_s1;

	// route state
	logic                in_route_q;
	logic [LOAD_W-1:0]   load_q;
	logic [NODE_W-1:0]   last_q;

	// stage 2: ops waiting for the queue
	op_t                 ops_s2 [3];
	logic [OPS_W-1:0]    cnt_s2;

	logic [DEMAND_W-1:0] demand;
	logic [LOAD_W-1:0]   load0;
	logic [LOAD_W-1:0]   load1;
	logic [LOAD_W-1:0]   new_load;
	logic [NODE_W-1:0]   last0;
	logic [NODE_W-1:0]   last1;
	logic                over;
	op_t                 ops [3];
	logic [OPS_W-1:0]    n_ops;
	logic                s2_free;
	logic                s1_adv;

	assign accept    = req.valid && req.ready;
	assign in_tbl    = 32'(req.node) < 32'(MAX_NODES);
	assign s2_free   = (cnt_s2 == '0) || (push && cnt_s2 == 2'd1);
	assign s1_adv    = valid_s1 && s2_free;
	assign req.ready = !valid_s1 || s1_adv;
	assign push      = (cnt_s2 != '0) && !full;
	assign push_op   = ops_s2[0];

	always_ff @(posedge clk) begin
		if (accept) begin
			if (req_type_t'(req.req_type) == REQ_LOAD_DEMAND && in_tbl) begin
				dem_mem[NW'(req.node)] <= req.value[DEMAND_W-1:0];
			end
			dem_rd_s1 <= dem_mem[NW'(req.node)];
			dem_ok_s1 <= in_tbl;
			type_s1   <= req_type_t'(req.req_type);
			node_s1   <= req.node;
			to_s1     <= req.to_node;
			value_s1  <= req.value;
			rend_s1   <= req.route_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// classify the item and expand it into ops: legs, distance writes and emits
	always_comb begin
		demand   = dem_ok_s1 ? dem_rd_s1 : '0;
		load0    = in_route_q ? load_q : '0;
		last0    = in_route_q ? last_q : depot_node;
		over     = ({1'b0, load0} + {2'b0, demand}) > {2'b0, vehicle_capacity};
		load1    = over ? '0 : load0;
		last1    = over ? depot_node : last0;
		new_load = load1 + {1'b0, demand};
		ops[0]   = '0;
		ops[1]   = '0;
		ops[2]   = '0;
		n_ops    = '0;
		case (type_s1)
			REQ_LOAD_DIST: begin
				ops[0].kind      = OP_WRITE;
				ops[0].from_node = node_s1;
				ops[0].to_node   = to_s1;
				ops[0].value     = value_s1;
				n_ops            = 2'd1;
			end
			REQ_VISIT: begin
				if (over) begin
					ops[0] = make_leg(last0, depot_node);
					ops[1] = make_leg(last1, node_s1);
					ops[2] = make_leg(node_s1, depot_node);
					n_ops  = rend_s1 ? 2'd3 : 2'd2;
				end else begin
					ops[0] = make_leg(last1, node_s1);
					ops[1] = make_leg(node_s1, depot_node);
					n_ops  = rend_s1 ? 2'd2 : 2'd1;
				end
			end
			REQ_END: begin
				if (in_route_q) begin
					ops[0]      = make_leg(last_q, depot_node);
					ops[1].kind = OP_EMIT;
					n_ops       = 2'd2;
				end else begin
					ops[0].kind = OP_EMIT;
					n_ops       = 2'd1;
				end
			end
			default: begin
				n_ops = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_route_q <= 1'b0;
			load_q     <= '0;
			last_q     <= '0;
		end else if (s1_adv) begin
			case (type_s1)
				REQ_VISIT: begin
					in_route_q <= !rend_s1;
					load_q     <= rend_s1 ? '0 : new_load;
					last_q     <= rend_s1 ? depot_node : node_s1;
				end
				REQ_END: begin
					in_route_q <= 1'b0;
					load_q     <= '0;
					last_q     <= depot_node;
				end
				default: begin
					in_route_q <= in_route_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			ops_s2[0] <= ops[0];
			ops_s2[1] <= ops[1];
			ops_s2[2] <= ops[2];
		end else if (push) begin
			ops_s2[0] <= ops_s2[1];
			ops_s2[1] <= ops_s2[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2 <= '0;
		end else if (s1_adv) begin
			cnt_s2 <= n_ops;
		end else if (push) begin
			cnt_s2 <= cnt_s2 - 2'd1;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/crt_queue.sv
`default_nettype none

module crt_queue import crt_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire op_t  push_op,
	output logic      full,
	input  wire logic pop,
	output logic      not_empty,
	output op_t       head
);

	op_t               mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full      = count_q == QCNT_W'(QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign head      = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

FILE: hdl/crt_back.sv
`default_nettype none

module crt_back import crt_pkg::*; #(
	parameter int MAX_NODES = 256,
	parameter int DIST_BITS = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_valid,
	input  wire op_t                q_op,
	output logic                    pop,
	input  wire logic [COUNT_W-1:0] node_count,
	crt_res_if.source               res
);

	localparam int AW = $clog2(MAX_NODES * MAX_NODES);

	logic [DIST_BITS-1:0] dist_mem [MAX_NODES * MAX_NODES];

	logic [AW-1:0]        addr;
	logic                 from_ok;
	logic                 to_ok;
	logic                 leg_ok;

	logic                 valid_b1;
	op_kind_t             kind_b1;
	logic                 ok_b1;
	logic [DIST_BITS-1:0] rd_b1;
	logic                 retire;

	logic [TOTAL_W-1:0]   total_q;
	logic                 invalid_q;
	logic [SUM_W-1:0]     sum;
	logic [TOTAL_W-1:0]   sat_sum;

	logic                 res_valid_q;
	logic [TOTAL_W-1:0]   res_total_q;
	logic                 res_invalid_q;

	assign addr    = AW'(q_op.from_node) * AW'(MAX_NODES) + AW'(q_op.to_node);
	assign from_ok = 32'(q_op.from_node) < 32'(MAX_NODES);
	assign to_ok   = 32'(q_op.to_node) < 32'(MAX_NODES);
	assign leg_ok  = from_ok && to_ok && (COUNT_W'(q_op.from_node) < node_count)
		&& (COUNT_W'(q_op.to_node) < node_count);

	// an emit waits only for the output register
	assign retire = valid_b1 && (kind_b1 != OP_EMIT || !res_valid_q || res.ready);
	assign pop    = q_valid && (!valid_b1 || retire);

	assign sum     = {1'b0, total_q} + SUM_W'(rd_b1);
	assign sat_sum = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];

	always_ff @(posedge clk) begin
		if (pop) begin
			if (q_op.kind == OP_WRITE && from_ok && to_ok) begin
				dist_mem[addr] <= DIST_BITS'(q_op.value);
			end
			rd_b1   <= dist_mem[addr];
			kind_b1 <= q_op.kind;
			ok_b1   <= leg_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_b1 <= 1'b0;
		end else if (pop) begin
			valid_b1 <= 1'b1;
		end else if (retire) begin
			valid_b1 <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= '0;
			invalid_q <= 1'b0;
		end else if (retire) begin
			case (kind_b1)
				OP_LEG: begin
					if (ok_b1) begin
						total_q <= sat_sum;
					end else begin
						invalid_q <= 1'b1;
					end
				end
				OP_EMIT: begin
					total_q   <= '0;
					invalid_q <= 1'b0;
				end
				default: begin
					total_q <= total_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (retire && kind_b1 == OP_EMIT) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (retire && kind_b1 == OP_EMIT) begin
			res_total_q   <= total_q;
			res_invalid_q <= invalid_q;
		end
	end

	assign res.valid          = res_valid_q;
	assign res.total_distance = res_total_q;
	assign res.invalid        = res_invalid_q;

`ifndef NO_ASSERTIONS
	a_leg_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		retire && kind_b1 == OP_LEG |=> total_q >= $past(total_q))
		else $error("running total went down on a leg");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		retire && kind_b1 == OP_EMIT |=> total_q == '0 && !invalid_q)
		else $error("total not cleared after emit");

	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		retire && kind_b1 == OP_EMIT |=> res.valid && res.total_distance == $past(total_q))
		else $error("emitted total does not match running total");
`endif

endmodule

`default_nettype wire

FILE: hdl/capacitated_route_cost_evaluator.sv
`default_nettype none

// channel  dir  handshake      payload
// cfg      in   valid/ready    index, data
// req      in   valid/ready    req_type, node, to_node, value, route_end
// res      out  valid/ready    total_distance, invalid
//
// a visit with no capacity return and no route end expands to one leg; each extra leg
// (return to depot, route close) adds one op to push; the distance memory has one port,
// one leg per cycle while no emit waits on res.ready; an end result passes stage 1,
// stage 2, the queue, the back-end read register and the result register
// reset (arst_n low) empties the pipeline and queue and clears route state,
// totals, capacity and depot; node count resets to 256; tables hold no reset value
// only the back end stalls on res.ready; the front holds req while it pushes extra
// legs and stops taking items while the four-entry queue is full, cfg is always ready

module capacitated_route_cost_evaluator import crt_pkg::*; #(
	parameter int MAX_NODES = 256,
	parameter int DIST_BITS = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	crt_cfg_if.sink   cfg,
	crt_req_if.sink   req,
	crt_res_if.source res
);

	// configuration registers
	logic [CAP_W-1:0]   vehicle_capacity_q;
	logic [NODE_W-1:0]  depot_node_q;
	logic [COUNT_W-1:0] node_count_q;

	// front to queue
	logic push;
	op_t  push_op;
	logic full;

	// queue to back
	logic pop;
	logic not_empty;
	op_t  head;

	// config writes go straight into the registers, so never back-pressure
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vehicle_capacity_q <= '0;
			depot_node_q       <= '0;
			node_count_q       <= NODE_COUNT_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				CFG_VEHICLE_CAPACITY: vehicle_capacity_q <= cfg.data[CAP_W-1:0];
				CFG_DEPOT_NODE:       depot_node_q       <= cfg.data[NODE_W-1:0];
				CFG_NODE_COUNT:       node_count_q       <= cfg.data[COUNT_W-1:0];
				default: begin
					// writes past the register list are dropped
					node_count_q <= node_count_q;
				end
			endcase
		end
	end

	// front: demand table, capacity check, route tracking, leg expansion
	crt_front #(
		.MAX_NODES(MAX_NODES)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.req              (req),
		.vehicle_capacity (vehicle_capacity_q),
		.depot_node       (depot_node_q),
		.push             (push),
		.push_op          (push_op),
		.full             (full)
	);

	// decoupling queue between classification and distance lookup
	crt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_op   (push_op),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	// back: distance memory, saturating accumulation, result register
	crt_back #(
		.MAX_NODES(MAX_NODES),
		.DIST_BITS(DIST_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (not_empty),
		.q_op       (head),
		.pop        (pop),
		.node_count (node_count_q),
		.res        (res)
	);

endmodule

`default_nettype wire
